// ===== rtl/core/tct_pkg.sv =====
// Shared types and constants of the TCP connection table.
// Depends on nothing; used by every module of the table.
package tct_pkg;

    localparam int IDX_W = 8;                // enough for up to 256 entries
    localparam int ENTRIES_DEF = 16;

    localparam logic [2:0] ACT_ALLOC  = 3'd0;
    localparam logic [2:0] ACT_FREE   = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_EXACT  = 3'd3;
    localparam logic [2:0] ACT_LISTEN = 3'd4;
    localparam logic [2:0] ACT_PORT   = 3'd5;

    localparam logic [7:0] REG_EPH_FIRST = 8'd0;
    localparam logic [7:0] REG_EPH_LAST  = 8'd1;
    localparam logic [7:0] REG_ISN_STEP  = 8'd2;

    localparam logic [15:0] EPH_FIRST_RESET = 16'd49152;
    localparam logic [15:0] EPH_LAST_RESET  = 16'd65535;
    localparam logic [31:0] ISN_STEP_RESET  = 32'd64000;
    localparam logic [31:0] ISN_RESET       = 32'h12345678;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             act;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } token_t;

    // Operation and key broadcast to every cell.
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic        listening;
    } bcast_t;

endpackage

// ===== rtl/core/tct_cell.sv =====
// One connection entry of the table and its step of the search chain.
// Depends on tct_pkg.
module tct_cell #(
    parameter int INDEX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  tct_pkg::bcast_t bc,
    input  tct_pkg::token_t tok_in,
    output tct_pkg::token_t tok_out
);

    logic        valid_reg, listen_reg;
    logic [31:0] laddr_reg, raddr_reg;
    logic [15:0] lport_reg, rport_reg;
    tct_pkg::token_t tok_reg, tok_next;
    logic        match, take;
    logic [tct_pkg::IDX_W-1:0] my_idx;

    assign my_idx = tct_pkg::IDX_W'(INDEX);

    always_comb begin
        unique case (bc.op)
            tct_pkg::ACT_ALLOC:  match = !valid_reg;
            tct_pkg::ACT_FREE,
            tct_pkg::ACT_WRITE:  match = ({4'b0, bc.slot} == my_idx);
            tct_pkg::ACT_EXACT:  match = valid_reg && lport_reg == bc.lport
                                     && rport_reg == bc.rport && raddr_reg == bc.raddr
                                     && (laddr_reg == 32'd0 || laddr_reg == bc.laddr);
            tct_pkg::ACT_LISTEN: match = valid_reg && listen_reg && lport_reg == bc.lport;
            tct_pkg::ACT_PORT:   match = valid_reg && lport_reg == bc.lport;
            default:             match = 1'b0;
        endcase
        take         = tok_in.act && !tok_in.hit && match;
        tok_next.act = tok_in.act;
        tok_next.hit = tok_in.hit || take;
        tok_next.idx = take ? my_idx : tok_in.idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            listen_reg  <= 1'b0;
            tok_reg.act <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (take) begin
                unique case (bc.op)
                    tct_pkg::ACT_ALLOC: begin
                        valid_reg  <= 1'b1;
                        listen_reg <= 1'b0;
                        laddr_reg  <= '0;
                        lport_reg  <= '0;
                        raddr_reg  <= '0;
                        rport_reg  <= '0;
                    end
                    tct_pkg::ACT_FREE: begin
                        valid_reg  <= 1'b0;
                        listen_reg <= 1'b0;
                    end
                    tct_pkg::ACT_WRITE: begin
                        listen_reg <= bc.listening;
                        laddr_reg  <= bc.laddr;
                        lport_reg  <= bc.lport;
                        raddr_reg  <= bc.raddr;
                        rport_reg  <= bc.rport;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/tct_ctrl.sv =====
// Sequencer of the table: handshakes, registers, ISN and port state.
// Depends on tct_pkg; drives the head of the cell chain.
module tct_ctrl #(
    parameter int ENTRIES = tct_pkg::ENTRIES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_action,
    input  logic [3:0]      s_slot,
    input  logic [31:0]     s_local_addr,
    input  logic [15:0]     s_local_port,
    input  logic [31:0]     s_remote_addr,
    input  logic [15:0]     s_remote_port,
    input  logic            s_listening,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_found,
    output logic [3:0]      m_result_slot,
    output logic [31:0]     m_isn,
    output logic [15:0]     m_port,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output tct_pkg::bcast_t bc,
    output tct_pkg::token_t tok_head,
    input  tct_pkg::token_t tok_tail
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t      state_reg;
    logic [15:0] first_reg, last_reg, next_port_reg, cand_reg, start_reg;
    logic [31:0] isn_step_reg, isn_ctr_reg;
    logic [2:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [31:0] laddr_reg, raddr_reg;
    logic [15:0] lport_reg, rport_reg;
    logic        listening_reg, launch_reg;
    logic        r_found_reg;
    logic [3:0]  r_slot_reg;
    logic [31:0] r_isn_reg;
    logic [15:0] r_port_reg;
    logic        m_valid_reg;
    logic [3:0]  m_slot_reg;
    logic        m_found_reg;
    logic [31:0] m_isn_reg;
    logic [15:0] m_port_reg;

    logic [15:0] init_cand, cand_next;
    logic        slot_ok, in_use;
    logic        skip_scan, retry, launch_next, push;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign init_cand = (next_port_reg < first_reg || next_port_reg > last_reg)
                       ? first_reg : next_port_reg;
    assign cand_next = (cand_reg == last_reg) ? first_reg : cand_reg + 16'd1;
    assign slot_ok   = ({5'b0, slot_reg} < 9'(ENTRIES));
    assign in_use    = tok_tail.hit || cand_reg == 16'd0;

    // Unused actions and an empty port range go straight to the result.
    assign skip_scan   = s_action > tct_pkg::ACT_PORT
                         || (s_action == tct_pkg::ACT_PORT && first_reg > last_reg);
    // Port in use and more candidates left: run the chain again.
    assign retry       = op_reg == tct_pkg::ACT_PORT && in_use && cand_next != start_reg;
    assign launch_next = (state_reg == ST_IDLE && s_valid && !skip_scan)
                         || (state_reg == ST_SCAN && tok_tail.act && retry);
    assign push        = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign bc.op        = op_reg;
    assign bc.slot      = slot_reg;
    assign bc.laddr     = laddr_reg;
    assign bc.lport     = (op_reg == tct_pkg::ACT_PORT) ? cand_reg : lport_reg;
    assign bc.raddr     = raddr_reg;
    assign bc.rport     = rport_reg;
    assign bc.listening = listening_reg;

    assign tok_head.act = launch_reg;
    assign tok_head.hit = 1'b0;
    assign tok_head.idx = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            first_reg     <= tct_pkg::EPH_FIRST_RESET;
            last_reg      <= tct_pkg::EPH_LAST_RESET;
            isn_step_reg  <= tct_pkg::ISN_STEP_RESET;
            isn_ctr_reg   <= tct_pkg::ISN_RESET;
            next_port_reg <= tct_pkg::EPH_FIRST_RESET;
            launch_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            launch_reg <= launch_next;
            if (push) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    tct_pkg::REG_EPH_FIRST: first_reg    <= cfg_data[15:0];
                    tct_pkg::REG_EPH_LAST:  last_reg     <= cfg_data[15:0];
                    tct_pkg::REG_ISN_STEP:  isn_step_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg        <= s_action;
                        slot_reg      <= s_slot;
                        laddr_reg     <= s_local_addr;
                        lport_reg     <= s_local_port;
                        raddr_reg     <= s_remote_addr;
                        rport_reg     <= s_remote_port;
                        listening_reg <= s_listening;
                        cand_reg      <= init_cand;
                        start_reg     <= init_cand;
                        r_found_reg   <= 1'b0;
                        r_slot_reg    <= '0;
                        r_isn_reg     <= '0;
                        r_port_reg    <= '0;
                        state_reg     <= skip_scan ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (tok_tail.act) begin
                        if (!retry) state_reg <= ST_DONE;
                        unique case (op_reg)
                            tct_pkg::ACT_FREE, tct_pkg::ACT_WRITE: begin
                                r_found_reg <= slot_ok;
                                r_slot_reg  <= slot_ok ? slot_reg : 4'd0;
                            end
                            tct_pkg::ACT_PORT: begin
                                if (!in_use) begin
                                    next_port_reg <= cand_next;
                                    r_found_reg   <= 1'b1;
                                    r_port_reg    <= cand_reg;
                                end else if (!retry) begin
                                    next_port_reg <= cand_next;
                                end else begin
                                    // try the next candidate port
                                    cand_reg <= cand_next;
                                end
                            end
                            default: begin
                                r_found_reg <= tok_tail.hit;
                                r_slot_reg  <= tok_tail.hit ? tok_tail.idx[3:0] : 4'd0;
                                if (op_reg == tct_pkg::ACT_ALLOC && tok_tail.hit) begin
                                    r_isn_reg   <= isn_ctr_reg;
                                    isn_ctr_reg <= isn_ctr_reg + isn_step_reg;
                                end
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    if (push) begin
                        m_found_reg <= r_found_reg;
                        m_slot_reg  <= r_slot_reg;
                        m_isn_reg   <= r_isn_reg;
                        m_port_reg  <= r_port_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_result_slot = m_slot_reg;
    assign m_isn         = m_isn_reg;
    assign m_port        = m_port_reg;

endmodule

// ===== rtl/core/tcp_connection_table.sv =====
// Top level of the TCP connection table: sequencer plus a chain of entry cells.
// Depends on tct_pkg, tct_cell and tct_ctrl.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid/s_ready, s_action .. s_listening | in
//  result  | m_valid/m_ready, m_found .. m_port       | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data | in
//
// Each request beat sends one token down the chain of ENTRIES cells, one cell
// per cycle; the sequencer latches the result, moves it into the output register
// once that is free and then waits idle for the next request beat. An ephemeral
// port request repeats the pass with each further candidate port until one is
// free or all are tried. Unused actions and an empty port range skip the chain.
// Reset clears all valid and listen marks at once; no clearing pass.
// A result held on a stalled m_ready side stalls the next result and keeps the
// sequencer busy; the next request beat is accepted as soon as it is idle.
module tcp_connection_table #(
    parameter int ENTRIES = tct_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_slot,
    input  logic [31:0] s_local_addr,
    input  logic [15:0] s_local_port,
    input  logic [31:0] s_remote_addr,
    input  logic [15:0] s_remote_port,
    input  logic        s_listening,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [3:0]  m_result_slot,
    output logic [31:0] m_isn,
    output logic [15:0] m_port,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tct_pkg::bcast_t bc;
    tct_pkg::token_t tok [ENTRIES+1];

    tct_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_action, .s_slot, .s_local_addr, .s_local_port,
        .s_remote_addr, .s_remote_port, .s_listening,
        .m_valid, .m_ready, .m_found, .m_result_slot, .m_isn, .m_port,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .bc, .tok_head(tok[0]), .tok_tail(tok[ENTRIES])
    );

    // Chain of entry cells; the first free or matching cell claims the token.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        tct_cell #(.INDEX(i)) u_cell (
            .aclk, .aresetn, .bc,
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

endmodule

// ===== rtl/core/tct_checker.sv =====
// Port-level checks of the TCP connection table, bound to the top level.
// Depends on tcp_connection_table only through its ports.
module tct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [3:0]  m_result_slot,
    input logic [31:0] m_isn,
    input logic [15:0] m_port
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_result_slot == 4'd0 && m_isn == 32'd0 && m_port == 16'd0)
        else $error("miss carries nonzero fields");

    a_port_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_port != 16'd0 |-> m_found && m_isn == 32'd0)
        else $error("port given without found");

endmodule

bind tcp_connection_table tct_checker u_tct_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_found, .m_result_slot, .m_isn, .m_port
);

// ===== test/tb_top.sv =====
// Self-checking testbench of the TCP connection table.
// Depends on tct_pkg and tcp_connection_table; a built-in table model predicts every result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;
    localparam int LIMIT = 200000;   // cycles with no beat on any channel

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [3:0]  s_slot = '0;
    logic [31:0] s_local_addr = '0;
    logic [15:0] s_local_port = '0;
    logic [31:0] s_remote_addr = '0;
    logic [15:0] s_remote_port = '0;
    logic        s_listening = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [3:0]  m_result_slot;
    logic [31:0] m_isn;
    logic [15:0] m_port;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    tcp_connection_table dut (.*);

    typedef struct packed {
        logic [2:0]  act;
        logic [3:0]  slot;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [31:0] raddr;
        logic [15:0] rport;
        logic        lsn;
    } request_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  rslot;
        logic [31:0] isn;
        logic [15:0] port;
    } lookup_t;

    // Table mirror
    logic        tbl_valid [NSLOT];
    logic        tbl_listen[NSLOT];
    logic [31:0] tbl_laddr [NSLOT];
    logic [15:0] tbl_lport [NSLOT];
    logic [31:0] tbl_raddr [NSLOT];
    logic [15:0] tbl_rport [NSLOT];
    logic [31:0] seq_ctr;
    logic [15:0] port_cursor;
    logic [15:0] eph_first, eph_last;
    logic [31:0] seq_step;

    lookup_t pending_results[$];
    int      fail_cnt = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;       // no idling in the last stretch
    bit      hold_sink = 1'b0;   // long receiver hold-off
    bit      pin_sink = 1'b0;    // fixed-length hold-off in progress

    function automatic bit port_taken(logic [15:0] p);
        if (p == 16'd0) return 1'b1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl_lport[i] == p) return 1'b1;
        return 1'b0;
    endfunction

    function automatic lookup_t table_step(request_t r);
        lookup_t     o;
        logic [15:0] p, start, cand;
        o = '{1'b0, 4'd0, 32'd0, 16'd0};
        case (r.act)
            tct_pkg::ACT_ALLOC: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_listen[i] = 1'b0;
                        tbl_laddr[i] = '0;
                        tbl_lport[i] = '0;
                        tbl_raddr[i] = '0;
                        tbl_rport[i] = '0;
                        o.isn = seq_ctr;
                        seq_ctr = seq_ctr + seq_step;
                        o.found = 1'b1;
                        o.rslot = 4'(i);
                        break;
                    end
                end
            end
            tct_pkg::ACT_FREE: begin
                tbl_valid[r.slot] = 1'b0;
                tbl_listen[r.slot] = 1'b0;
                o.found = 1'b1;
                o.rslot = r.slot;
            end
            tct_pkg::ACT_WRITE: begin
                tbl_laddr[r.slot] = r.laddr;
                tbl_lport[r.slot] = r.lport;
                tbl_raddr[r.slot] = r.raddr;
                tbl_rport[r.slot] = r.rport;
                tbl_listen[r.slot] = r.lsn;
                o.found = 1'b1;
                o.rslot = r.slot;
            end
            tct_pkg::ACT_EXACT: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i] && tbl_lport[i] == r.lport && tbl_rport[i] == r.rport
                        && (tbl_laddr[i] == 0 || tbl_laddr[i] == r.laddr)
                        && tbl_raddr[i] == r.raddr) begin
                        o.found = 1'b1;
                        o.rslot = 4'(i);
                        break;
                    end
                end
            end
            tct_pkg::ACT_LISTEN: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i] && tbl_listen[i] && tbl_lport[i] == r.lport) begin
                        o.found = 1'b1;
                        o.rslot = 4'(i);
                        break;
                    end
                end
            end
            tct_pkg::ACT_PORT: begin
                if (eph_first <= eph_last) begin
                    p = port_cursor;
                    if (p < eph_first || p > eph_last) p = eph_first;
                    start = p;
                    forever begin
                        cand = p;
                        p = (p == eph_last) ? eph_first : p + 16'd1;
                        if (!port_taken(cand)) begin
                            port_cursor = p;
                            o.port = cand;
                            break;
                        end
                        if (p == start) begin
                            port_cursor = p;
                            break;
                        end
                    end
                    o.found = (o.port != 0);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Random gap in the request stream, mostly none
    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
    endtask

    // Offer one beat, hold it until accepted, then predict; valid stays up
    // so that the next beat can follow at once
    task automatic send(request_t r);
        s_valid <= 1'b1;
        s_action <= r.act;
        s_slot <= r.slot;
        s_local_addr <= r.laddr;
        s_local_port <= r.lport;
        s_remote_addr <= r.raddr;
        s_remote_port <= r.rport;
        s_listening <= r.lsn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(table_step(r));
        @(negedge aclk);
    endtask

    // Send a beat whose result is known up front, and check the prediction too
    task automatic send_known(request_t r, lookup_t want);
        lookup_t got;
        send(r);
        got = pending_results[$];
        if (got != want) begin
            $display("%0t: table prediction exp %p act %p", $time, want, got);
            fail_cnt++;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (NSLOT * 70) @(negedge aclk);   // idle stretch before register changes
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            tct_pkg::REG_EPH_FIRST: eph_first = val[15:0];
            tct_pkg::REG_EPH_LAST:  eph_last = val[15:0];
            tct_pkg::REG_ISN_STEP:  seq_step = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic request_t rnd_req(logic [2:0] act);
        request_t r;
        r.act = act;
        r.slot = 4'($urandom_range(0, 15));
        // small pools so lookups hit often
        r.laddr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        r.lport = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'(eph_first + $urandom_range(0, 5));
        r.raddr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        r.rport = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        r.lsn = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Result side: check each beat against the oldest prediction
    always @(posedge aclk) begin
        lookup_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b slot=%0d", $time,
                         m_found, m_result_slot);
                fail_cnt++;
            end else begin
                w = pending_results.pop_front();
                if (m_found !== w.found) begin
                    $display("%0t: found exp %0b act %0b", $time, w.found, m_found);
                    fail_cnt++;
                end
                if (m_result_slot !== w.rslot) begin
                    $display("%0t: slot exp %0d act %0d", $time, w.rslot, m_result_slot);
                    fail_cnt++;
                end
                if (m_isn !== w.isn) begin
                    $display("%0t: isn exp %h act %h", $time, w.isn, m_isn);
                    fail_cnt++;
                end
                if (m_port !== w.port) begin
                    $display("%0t: port exp %0d act %0d", $time, w.port, m_port);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver stalls: random bursts, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_sink) begin
            if (!pin_sink) begin
                pin_sink = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                pin_sink = 1'b0;
                hold_sink = 1'b0;
            end
        end else if (quiet || $urandom_range(0, 7) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
        end
    end

    // Watchdog: count cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    request_t directed[$];
    lookup_t  known[$];
    bit       has_known[$];

    // Queue one directed row
    task automatic row(logic [2:0] a, logic [3:0] sl, logic [31:0] la, logic [15:0] lp,
                       logic [31:0] ra, logic [15:0] rp, logic ls, bit k, lookup_t w);
        directed.push_back('{a, sl, la, lp, ra, rp, ls});
        has_known.push_back(k);
        known.push_back(w);
    endtask

    initial begin
        lookup_t  nil;
        request_t r;
        int       n;
        nil = '{1'b0, 4'd0, 32'd0, 16'd0};
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 0; tbl_listen[i] = 0;
            tbl_laddr[i] = 0; tbl_lport[i] = 0; tbl_raddr[i] = 0; tbl_rport[i] = 0;
        end
        seq_ctr = tct_pkg::ISN_RESET;
        port_cursor = tct_pkg::EPH_FIRST_RESET;
        eph_first = tct_pkg::EPH_FIRST_RESET;
        eph_last = tct_pkg::EPH_LAST_RESET;
        seq_step = tct_pkg::ISN_STEP_RESET;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows: reset values, extremes, each action and corner case
        row(tct_pkg::ACT_EXACT, 0, 0, 0, 0, 0, 0, 1, nil);             // empty table
        row(tct_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0, 1, '{1, 0, tct_pkg::ISN_RESET, 0});
        row(tct_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0, 1,
            '{1, 1, tct_pkg::ISN_RESET + tct_pkg::ISN_STEP_RESET, 0});
        row(tct_pkg::ACT_PORT, 0, 0, 0, 0, 0, 0, 1, '{1, 0, 0, tct_pkg::EPH_FIRST_RESET});
        row(tct_pkg::ACT_WRITE, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1,
            '{1, 0, 0, 0});
        row(tct_pkg::ACT_WRITE, 1, 0, 16'd49153, 32'h0A00_0001, 16'd80, 0, 1,
            '{1, 1, 0, 0});
        row(tct_pkg::ACT_EXACT, 0, 32'h1234, 16'd49153, 32'h0A00_0001, 16'd80, 0, 0,
            nil);                                                       // wildcard
        row(tct_pkg::ACT_EXACT, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
            nil);
        row(tct_pkg::ACT_LISTEN, 0, 0, 16'hFFFF, 0, 0, 0, 0, nil);
        row(tct_pkg::ACT_PORT, 0, 0, 0, 0, 0, 0, 0, nil);              // skips in-use port
        row(tct_pkg::ACT_WRITE, 15, 1, 2, 3, 4, 1, 1, '{1, 15, 0, 0}); // not valid entry
        row(tct_pkg::ACT_LISTEN, 0, 0, 2, 0, 0, 0, 0, nil);
        row(tct_pkg::ACT_FREE, 15, 0, 0, 0, 0, 0, 1, '{1, 15, 0, 0});  // already free
        row(tct_pkg::ACT_FREE, 0, 0, 0, 0, 0, 0, 1, '{1, 0, 0, 0});
        row(3'd6, 0, 0, 0, 0, 0, 0, 1, nil);
        row(3'd7, 15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, nil);
        for (int i = 0; i < directed.size(); i++) begin
            if (has_known[i]) send_known(directed[i], known[i]);
            else send(directed[i]);
        end
        // Fill the table, then alloc on a full table
        for (int i = 0; i < 15; i++) send(rnd_req(tct_pkg::ACT_ALLOC));
        send_known('{tct_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0}, nil);

        // Register extremes: empty range, single port, wrap, large step
        drain();
        cfg_write(tct_pkg::REG_EPH_FIRST, 32'd10);
        cfg_write(tct_pkg::REG_EPH_LAST, 32'd9);
        cfg_write(tct_pkg::REG_ISN_STEP, 32'hFFFF_FFFF);
        cfg_write(8'd200, 32'hDEAD_BEEF);                               // unused index
        send_known('{tct_pkg::ACT_PORT, 0, 0, 0, 0, 0, 0}, nil);
        drain();
        cfg_write(tct_pkg::REG_EPH_FIRST, 32'd0);
        cfg_write(tct_pkg::REG_EPH_LAST, 32'd1);                        // port zero skipped
        for (int i = 0; i < 4; i++) send(rnd_req(tct_pkg::ACT_PORT));
        send('{tct_pkg::ACT_FREE, 3, 0, 0, 0, 0, 0});
        send('{tct_pkg::ACT_ALLOC, 0, 0, 0, 0, 0, 0});
        drain();
        cfg_write(tct_pkg::REG_EPH_FIRST, 32'd65530);
        cfg_write(tct_pkg::REG_EPH_LAST, 32'd65535);
        cfg_write(tct_pkg::REG_ISN_STEP, 32'd0);

        // Random phases; each ends idle, and all but the last with a register change
        for (int ph = 0; ph < 6; ph++) begin
            n = 0;
            // the sender pauses until all results are back
            if (ph == 2) drain();
            // long receiver hold-off while the sender keeps offering
            if (ph == 3) hold_sink = 1'b1;
            if (ph == 5) quiet = 1'b1;
            while (n < 100) begin
                case ($urandom_range(0, 9))
                    0, 1:    r = rnd_req(tct_pkg::ACT_ALLOC);
                    2:       r = rnd_req(tct_pkg::ACT_FREE);
                    3, 4:    r = rnd_req(tct_pkg::ACT_WRITE);
                    5, 6:    r = rnd_req(tct_pkg::ACT_EXACT);
                    7:       r = rnd_req(tct_pkg::ACT_LISTEN);
                    8:       r = rnd_req(tct_pkg::ACT_PORT);
                    default: r = rnd_req(3'($urandom_range(0, 7)));
                endcase
                send(r);
                n++;
                maybe_gap();
            end
            drain();
            if (ph < 5) begin
                cfg_write(tct_pkg::REG_EPH_FIRST,
                          $urandom_range(1, 3) * 32'd20000 + $urandom_range(0, 3));
                cfg_write(tct_pkg::REG_EPH_LAST,
                          (ph == 1) ? 32'd65535 : 32'(eph_first) + $urandom_range(0, 8));
                cfg_write(tct_pkg::REG_ISN_STEP, (ph == 0) ? 32'hFFFF_FFFF : $urandom);
            end
        end

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
